// ===== hw/rtl/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg: shared definitions for the rational arithmetic unit
// Operation codes, result field widths, comparison and status codes.
// ----------------------------------------------------------------------------
package rau_pkg;

  // Result field widths (fixed, independent of the operand width).
  localparam int RES_NUM_W = 33;
  localparam int RES_DEN_W = 31;
  localparam int CMP_W     = 2;
  localparam int OP_W      = 3;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB    = 3'd1;
  localparam logic [OP_W-1:0] OP_MUL    = 3'd2;
  localparam logic [OP_W-1:0] OP_DIV    = 3'd3;
  localparam logic [OP_W-1:0] OP_CMP    = 3'd4;
  localparam logic [OP_W-1:0] OP_REDUCE = 3'd5;

  // Comparison outcome, as a 2-bit signed value.
  localparam logic [CMP_W-1:0] CMP_A_GREATER = 2'b11;
  localparam logic [CMP_W-1:0] CMP_A_SMALLER = 2'b01;
  localparam logic [CMP_W-1:0] CMP_EQUAL     = 2'b00;

  // Status codes.
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_ZERO_DEN = 1'b1;

endpackage

// ===== hw/rtl/rau_req_if.sv =====
// ----------------------------------------------------------------------------
// rau_req_if: request channel of the rational arithmetic unit
// Valid/ready handshake carrying the op code and two signed fractions.
// ----------------------------------------------------------------------------
interface rau_req_if #(
  parameter int OPERAND_WIDTH = 16
);
  logic                            valid;
  logic                            ready;
  logic [rau_pkg::OP_W-1:0]        op;
  logic signed [OPERAND_WIDTH-1:0] a_num;
  logic signed [OPERAND_WIDTH-1:0] a_den;
  logic signed [OPERAND_WIDTH-1:0] b_num;
  logic signed [OPERAND_WIDTH-1:0] b_den;

  modport source (output valid, op, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, op, a_num, a_den, b_num, b_den, output ready);
endinterface

// ===== hw/rtl/rau_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rau_rsp_if: result channel of the rational arithmetic unit
// Valid/ready handshake carrying the result fraction, compare and status.
// ----------------------------------------------------------------------------
interface rau_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [rau_pkg::RES_NUM_W-1:0] res_num;
  logic [rau_pkg::RES_DEN_W-1:0]      res_den;
  logic signed [rau_pkg::CMP_W-1:0]   cmp_result;
  logic                               status;

  modport source (output valid, res_num, res_den, cmp_result, status, input ready);
  modport sink   (input valid, res_num, res_den, cmp_result, status, output ready);
endinterface

// ===== hw/rtl/rau_divider.sv =====
// ----------------------------------------------------------------------------
// rau_divider: iterative unsigned divider
// Restoring division, one quotient bit per cycle; done pulses high once the
// last quotient bit has been formed.
// ----------------------------------------------------------------------------
module rau_divider #(
  parameter int W = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);

  localparam int CW = $clog2(W + 1);

  logic [CW-1:0] cnt;
  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [W-1:0]  dvs;
  logic [W:0]    shifted;
  logic [W:0]    diff;
  logic          fits;

  // Bring down the next dividend bit and try to subtract the divisor.
  assign shifted = {rem, quo[W-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign fits    = ~diff[W];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CW'(W);
      end else if (cnt != '0) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (cnt != '0) begin
      rem <= fits ? diff[W-1:0] : shifted[W-1:0];
      quo <= {quo[W-2:0], fits};
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// ===== hw/rtl/rational_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: exact arithmetic on two signed fractions
// Add, subtract, multiply, divide, compare and reduce with Euclid GCD.
// ----------------------------------------------------------------------------
// Usage: a request item on req carries an op code and two fractions
// a = a_num/a_den and b = b_num/b_den; exactly one result item leaves on rsp.
// Both channels use valid/ready; an item moves when both are high.
// req.ready is high only while the sequencer is idle, so one item is in work
// at a time. A finished result sits in the rsp output register, and the next
// request is taken while that register still waits for the receiver.
// Sequence: add, subtract, multiply, divide and compare form three products
// on the shared multiplier in S_M0, S_M1 and S_M2, combine them in S_FIN and
// load the output register in S_OUT. Reduce runs Euclid modulo steps on the
// shared iterative divider, and two more divisions by the GCD give the
// reduced numerator and denominator. Zero denominators, unused op codes and a
// zero numerator on reduce go straight to S_OUT. The next request can be
// taken once the output register has loaded. A stalled receiver holds the
// result and the block waits with its next one. Reset (rst) clears the
// sequencer and the output valid and keeps req.ready low.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic         clk,
  input  logic         rst,
  rau_req_if.sink      req,
  rau_rsp_if.source    rsp
);

  localparam int W  = OPERAND_WIDTH;
  localparam int NW = W + 1;       // sign-normalized operand
  localparam int PW = 2 * NW;      // product and combined result
  localparam int XW = (PW > rau_pkg::RES_NUM_W) ? PW : rau_pkg::RES_NUM_W;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_M0    = 12'b000000000010,
    S_M1    = 12'b000000000100,
    S_M2    = 12'b000000001000,
    S_FIN   = 12'b000000010000,
    S_EUC   = 12'b000000100000,
    S_EUC_W = 12'b000001000000,
    S_QN    = 12'b000010000000,
    S_QN_W  = 12'b000100000000,
    S_QD    = 12'b001000000000,
    S_QD_W  = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_t;

  state_t state;

  // Sign normalization of the incoming fractions: a negative denominator
  // negates both numerator and denominator.
  logic signed [NW-1:0] a_num_x, a_den_x, b_num_x, b_den_x;
  logic signed [NW-1:0] an_n, ad_n, bn_n, bd_n;
  logic [W-1:0]         an_abs_n;
  logic                 op_known;
  logic                 in_bad;
  logic                 accept;

  assign a_num_x = {req.a_num[W-1], req.a_num};
  assign a_den_x = {req.a_den[W-1], req.a_den};
  assign b_num_x = {req.b_num[W-1], req.b_num};
  assign b_den_x = {req.b_den[W-1], req.b_den};

  assign an_n = a_den_x[NW-1] ? -a_num_x : a_num_x;
  assign ad_n = a_den_x[NW-1] ? -a_den_x : a_den_x;
  assign bn_n = b_den_x[NW-1] ? -b_num_x : b_num_x;
  assign bd_n = b_den_x[NW-1] ? -b_den_x : b_den_x;

  // The magnitude is at most 2^(W-1), so it fits W unsigned bits.
  always_comb begin
    logic signed [NW-1:0] neg;
    neg      = -an_n;
    an_abs_n = an_n[NW-1] ? neg[W-1:0] : an_n[W-1:0];
  end

  assign op_known = (req.op <= rau_pkg::OP_REDUCE);
  assign in_bad   = op_known &&
                    ((ad_n == '0) || ((req.op != rau_pkg::OP_REDUCE) && (bd_n == '0)));

  assign req.ready = (state == S_IDLE) && !rst;
  assign accept    = req.valid && req.ready;

  // Operand registers.
  logic [rau_pkg::OP_W-1:0] op_r;
  logic signed [NW-1:0]     an, ad, bn, bd;
  logic [W-1:0]             an_mag;

  // Shared multiplier: one product per cycle, each into its own register.
  //   p0 = an * bd (an * bn for multiply), p1 = bn * ad, p2 = ad * bd.
  logic signed [NW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] p0, p1, p2;

  always_comb begin
    case (state)
      S_M0: begin
        mul_a = an;
        mul_b = (op_r == rau_pkg::OP_MUL) ? bn : bd;
      end
      S_M1: begin
        mul_a = bn;
        mul_b = ad;
      end
      default: begin
        mul_a = ad;
        mul_b = bd;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Shared divider: Euclid modulo steps, then the two quotients by the GCD.
  logic [W-1:0] gx, gy, qn;
  logic         div_start, div_done;
  logic [W-1:0] div_dividend, div_divisor, div_quo, div_rem;

  assign div_start = ((state == S_EUC) && (gy != '0)) || (state == S_QN) ||
                     (state == S_QD);

  always_comb begin
    case (state)
      S_EUC:   div_dividend = gx;
      S_QN:    div_dividend = an_mag;
      default: div_dividend = ad[W-1:0];
    endcase
    div_divisor = (state == S_EUC) ? gy : gx;
  end

  rau_divider #(
    .W (W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Result formation: from the products, or from the reduced quotients.
  logic signed [PW-1:0]    sum, neg0, neg1, qn_p, qd_p;
  logic signed [PW-1:0]    fin_num, fin_den;
  logic signed [XW-1:0]    fin_num_x, fin_den_x;
  logic [rau_pkg::CMP_W-1:0] fin_cmp;
  logic                    fin_bad;

  assign sum  = (op_r == rau_pkg::OP_SUB) ? (p0 - p1) : (p0 + p1);
  assign neg0 = -p0;
  assign neg1 = -p1;
  assign qn_p = $signed(PW'(qn));
  assign qd_p = $signed(PW'(div_quo));

  always_comb begin
    fin_num = '0;
    fin_den = '0;
    fin_cmp = rau_pkg::CMP_EQUAL;
    fin_bad = 1'b0;
    if (state == S_QD_W) begin
      fin_num = an[NW-1] ? -qn_p : qn_p;
      fin_den = qd_p;
    end else begin
      case (op_r)
        rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
          fin_num = sum;
          fin_den = p2;
        end
        rau_pkg::OP_MUL: begin
          fin_num = p0;
          fin_den = p2;
        end
        rau_pkg::OP_DIV: begin
          // Dividing by a zero numerator leaves a zero denominator.
          if (p1 == '0) begin
            fin_bad = 1'b1;
          end else if (p1[PW-1]) begin
            fin_num = neg0;
            fin_den = neg1;
          end else begin
            fin_num = p0;
            fin_den = p1;
          end
        end
        rau_pkg::OP_CMP: begin
          if (p0 > p1) begin
            fin_cmp = rau_pkg::CMP_A_GREATER;
          end else if (p0 < p1) begin
            fin_cmp = rau_pkg::CMP_A_SMALLER;
          end
        end
        default: begin
          fin_num = '0;
        end
      endcase
    end
  end

  assign fin_num_x = XW'(fin_num);
  assign fin_den_x = XW'(fin_den);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (!op_known || in_bad) begin
              state <= S_OUT;
            end else if (req.op == rau_pkg::OP_REDUCE) begin
              state <= (an_n == '0) ? S_OUT : S_EUC;
            end else begin
              state <= S_M0;
            end
          end
        end
        S_M0:    state <= S_M1;
        S_M1:    state <= S_M2;
        S_M2:    state <= S_FIN;
        S_FIN:   state <= S_OUT;
        S_EUC:   state <= (gy == '0) ? S_QN : S_EUC_W;
        S_EUC_W: if (div_done) begin
          state <= S_EUC;
        end
        S_QN:    state <= S_QN_W;
        S_QN_W:  if (div_done) begin
          state <= S_QD;
        end
        S_QD:    state <= S_QD_W;
        S_QD_W:  if (div_done) begin
          state <= S_OUT;
        end
        S_OUT:   if (!rsp.valid || rsp.ready) begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  logic signed [rau_pkg::RES_NUM_W-1:0] res_num;
  logic [rau_pkg::RES_DEN_W-1:0]        res_den;
  logic [rau_pkg::CMP_W-1:0]            res_cmp;
  logic                                 res_status;

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= req.op;
      an      <= an_n;
      ad      <= ad_n;
      bn      <= bn_n;
      bd      <= bd_n;
      an_mag  <= an_abs_n;
      gx      <= an_abs_n;
      gy      <= ad_n[W-1:0];
      // Trivial outcomes are settled right away.
      res_num    <= '0;
      res_cmp    <= rau_pkg::CMP_EQUAL;
      res_status <= in_bad ? rau_pkg::STATUS_ZERO_DEN : rau_pkg::STATUS_OK;
      res_den    <= (op_known && !in_bad && req.op == rau_pkg::OP_REDUCE)
                    ? rau_pkg::RES_DEN_W'(1) : '0;
    end
    if (state == S_M0) begin
      p0 <= prod;
    end
    if (state == S_M1) begin
      p1 <= prod;
    end
    if (state == S_M2) begin
      p2 <= prod;
    end
    if ((state == S_EUC_W) && div_done) begin
      gx <= gy;
      gy <= div_rem;
    end
    if ((state == S_QN_W) && div_done) begin
      qn <= div_quo;
    end
    if ((state == S_FIN) || ((state == S_QD_W) && div_done)) begin
      res_num    <= fin_num_x[rau_pkg::RES_NUM_W-1:0];
      res_den    <= fin_den_x[rau_pkg::RES_DEN_W-1:0];
      res_cmp    <= fin_cmp;
      res_status <= fin_bad ? rau_pkg::STATUS_ZERO_DEN : rau_pkg::STATUS_OK;
    end
  end

  // Output register: loaded from the result once the receiver has room.
  logic out_load;

  assign out_load = (state == S_OUT) && (!rsp.valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.res_num    <= res_num;
      rsp.res_den    <= res_den;
      rsp.cmp_result <= res_cmp;
      rsp.status     <= res_status;
    end
  end

endmodule
